[rtl/nwcs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the nearest walkable cell search block.
// No dependencies; every other file but nwcs_bitmap imports this package.
package nwcs_pkg;

  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 7;
  localparam int RANGE_W    = 6;
  localparam int DIST_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RANGE = 2'd2;

  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic wr_cell;      // write the input beat's cell into the bitmap
    logic q_load;       // latch the clamped query cell
    logic rd_center;    // read the bitmap at the query cell
    logic take_center;  // capture the query cell's blocked bit
    logic ring_first;   // start the ring search at radius one
    logic seg_load;     // load start and end of the current ring segment
    logic scan;         // read one segment cell and advance
    logic seg_next;     // move to the next segment of the ring
    logic ring_next;    // move to the next ring
    logic load_out;     // load the result register
  } nwcs_cmd_t;

  typedef struct packed {
    logic clr_busy;
    logic center_blocked;
    logic range_zero;
    logic seg_en;
    logic seg_last;
    logic scan_last;
    logic have;
    logic ring_last;
  } nwcs_status_t;

endpackage

[rtl/nwcs_bitmap.sv]
`timescale 1ns / 1ps
// Blocked-cell bitmap: one bit per cell, one write and one registered read per cycle.
// Runs a clearing pass over every entry after reset. No package dependencies.
module nwcs_bitmap #(
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic          wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic          rd_data_o,
  output logic          clr_busy_o
);

  logic          mem_q [DEPTH];
  logic          rd_data_q;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_busy_q, clr_busy_d;
  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // the clearing pass owns the write port until it is done
  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_cnt_q : wr_addr_i;
  assign wdata = clr_busy_q ? 1'b0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !wr_en_i)
    else $error("bitmap write issued during clearing pass");

endmodule

[rtl/nwcs_datapath.sv]
`timescale 1ns / 1ps
// Datapath: configuration registers, query clamp, ring walk, best-cell tracking
// and result register. Uses nwcs_pkg and instantiates nwcs_bitmap.
module nwcs_datapath import nwcs_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  coord_t                cell_x_i,
  input  coord_t                cell_y_i,
  input  logic                  blocked_i,
  input  nwcs_cmd_t             cmd_i,
  output nwcs_status_t          status_o,
  output logic                  found_o,
  output logic                  relocated_o,
  output coord_t                result_x_o,
  output coord_t                result_y_o
);

  localparam int XS    = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int YS    = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
  localparam int DEPTH = XS * YS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [SIZE_W-1:0] W_CAP = SIZE_W'(XS);
  localparam logic [SIZE_W-1:0] H_CAP = SIZE_W'(YS);

  localparam logic [1:0] SEG_LEFT  = 2'd0;
  localparam logic [1:0] SEG_RIGHT = 2'd1;
  localparam logic [1:0] SEG_UPPER = 2'd2;
  localparam logic [1:0] SEG_LOWER = 2'd3;

  function automatic logic [AW-1:0] addr_of(input coord_t x, input coord_t y);
    return AW'(y) * AW'(XS) + AW'(x);
  endfunction

  // configuration
  logic [SIZE_W-1:0]  gw_q, gh_q;
  logic [RANGE_W-1:0] sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= SIZE_W'(64);
      gh_q <= SIZE_W'(64);
      sr_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:   gw_q <= cfg_data_i;
        REG_GRID_HEIGHT:  gh_q <= cfg_data_i;
        REG_SEARCH_RANGE: sr_q <= cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // grid in use
  logic [SIZE_W-1:0] w_eff, h_eff, w_m1_full, h_m1_full;
  coord_t            wm1, hm1;

  always_comb begin
    w_eff = gw_q;
    if (gw_q == '0) w_eff = SIZE_W'(1);
    if (gw_q > W_CAP) w_eff = W_CAP;
    h_eff = gh_q;
    if (gh_q == '0) h_eff = SIZE_W'(1);
    if (gh_q > H_CAP) h_eff = H_CAP;
  end

  assign w_m1_full = w_eff - SIZE_W'(1);
  assign h_m1_full = h_eff - SIZE_W'(1);
  assign wm1       = w_m1_full[COORD_W-1:0];
  assign hm1       = h_m1_full[COORD_W-1:0];

  // query state
  coord_t             cx_q, cy_q;
  logic [RANGE_W-1:0] r_q;
  logic [1:0]         seg_q;
  coord_t             sx_q, sy_q, end_q;
  logic               pv_q;
  coord_t             px_q, py_q;
  logic               have_q;
  logic [DIST_W-1:0]  bd_q;
  coord_t             bx_q, by_q;
  logic               reloc_q;
  logic               found_q, relocated_q;
  coord_t             rx_q, ry_q;

  logic rd_data;
  logic clr_busy;

  // ring bounds, clipped to the grid
  logic [SIZE_W-1:0] cx_w, cy_w, r_w, x_hi_sum, y_hi_sum;
  logic              left_ok, right_ok, up_ok, low_ok;
  coord_t            xlo, xhi, ylo, yhi;

  assign cx_w     = {1'b0, cx_q};
  assign cy_w     = {1'b0, cy_q};
  assign r_w      = {1'b0, r_q};
  assign x_hi_sum = cx_w + r_w;
  assign y_hi_sum = cy_w + r_w;
  assign left_ok  = r_w <= cx_w;
  assign right_ok = x_hi_sum < w_eff;
  assign up_ok    = y_hi_sum < h_eff;
  assign low_ok   = r_w <= cy_w;
  assign xlo      = left_ok  ? cx_q - r_q : '0;
  assign xhi      = right_ok ? x_hi_sum[COORD_W-1:0] : wm1;
  assign ylo      = low_ok   ? cy_q - r_q : '0;
  assign yhi      = up_ok    ? y_hi_sum[COORD_W-1:0] : hm1;

  logic   seg_en, vert;
  coord_t st_x, st_y, st_end;

  always_comb begin
    seg_en = 1'b0;
    st_x   = xlo;
    st_y   = ylo;
    st_end = yhi;
    case (seg_q)
      SEG_LEFT: begin
        seg_en = left_ok;
      end
      SEG_RIGHT: begin
        seg_en = right_ok;
        st_x   = x_hi_sum[COORD_W-1:0];
      end
      SEG_UPPER: begin
        seg_en = up_ok;
        st_y   = y_hi_sum[COORD_W-1:0];
        st_end = xhi;
      end
      SEG_LOWER: begin
        seg_en = low_ok;
        st_end = xhi;
      end
      default: ;
    endcase
  end

  assign vert = (seg_q == SEG_LEFT) || (seg_q == SEG_RIGHT);

  // clamped query cell
  coord_t cx_in, cy_in;
  assign cx_in = (cell_x_i > wm1) ? wm1 : cell_x_i;
  assign cy_in = (cell_y_i > hm1) ? hm1 : cell_y_i;

  // distance of the cell whose read data is now back
  coord_t            dx, dy;
  logic [DIST_W-1:0] cell_dist;
  logic              better;

  assign dx        = (px_q >= cx_q) ? px_q - cx_q : cx_q - px_q;
  assign dy        = (py_q >= cy_q) ? py_q - cy_q : cy_q - py_q;
  assign cell_dist = {1'b0, dx} + {1'b0, dy};
  assign better    = pv_q && !rd_data && (!have_q || (cell_dist < bd_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q     <= '0;
      seg_q   <= SEG_LEFT;
      pv_q    <= 1'b0;
      have_q  <= 1'b0;
      reloc_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.scan;
      if (cmd_i.q_load) begin
        have_q <= 1'b0;
      end else if (better) begin
        have_q <= 1'b1;
      end
      if (cmd_i.take_center) reloc_q <= rd_data;
      if (cmd_i.ring_first) begin
        r_q   <= RANGE_W'(1);
        seg_q <= SEG_LEFT;
      end else if (cmd_i.ring_next) begin
        r_q   <= r_q + RANGE_W'(1);
        seg_q <= SEG_LEFT;
      end else if (cmd_i.seg_next) begin
        seg_q <= seg_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      cx_q <= cx_in;
      cy_q <= cy_in;
    end
    if (cmd_i.seg_load) begin
      sx_q  <= st_x;
      sy_q  <= st_y;
      end_q <= st_end;
    end else if (cmd_i.scan) begin
      if (vert) begin
        sy_q <= sy_q + COORD_W'(1);
      end else begin
        sx_q <= sx_q + COORD_W'(1);
      end
    end
    px_q <= sx_q;
    py_q <= sy_q;
    if (better) begin
      bd_q <= cell_dist;
      bx_q <= px_q;
      by_q <= py_q;
    end
    if (cmd_i.load_out) begin
      found_q     <= !reloc_q || have_q;
      relocated_q <= reloc_q;
      rx_q        <= (reloc_q && have_q) ? bx_q : cx_q;
      ry_q        <= (reloc_q && have_q) ? by_q : cy_q;
    end
  end

  // bitmap ports
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  coord_t        rd_x, rd_y;

  assign wr_en   = cmd_i.wr_cell && ({1'b0, cell_x_i} < W_CAP) && ({1'b0, cell_y_i} < H_CAP);
  assign wr_addr = addr_of(cell_x_i, cell_y_i);
  assign rd_x    = cmd_i.rd_center ? cx_q : sx_q;
  assign rd_y    = cmd_i.rd_center ? cy_q : sy_q;
  assign rd_addr = addr_of(rd_x, rd_y);

  nwcs_bitmap #(
    .DEPTH(DEPTH)
  ) u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (blocked_i),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  always_comb begin
    status_o.clr_busy       = clr_busy;
    status_o.center_blocked = rd_data;
    status_o.range_zero     = (sr_q == '0);
    status_o.seg_en         = seg_en;
    status_o.seg_last       = (seg_q == SEG_LOWER);
    status_o.scan_last      = vert ? (sy_q == end_q) : (sx_q == end_q);
    status_o.have           = have_q;
    status_o.ring_last      = (r_q == sr_q);
  end

  assign found_o     = found_q;
  assign relocated_o = relocated_q;
  assign result_x_o  = rx_q;
  assign result_y_o  = ry_q;

  // any cell on ring r lies at least r away from the query cell
  a_best_not_inside_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (bd_q >= {1'b0, r_q}))
    else $error("best distance smaller than current ring radius");

endmodule

[rtl/nwcs_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences writes, the query cell check and the ring-by-ring scan,
// and owns the result valid flag. Uses nwcs_pkg command and status types.
module nwcs_ctrl import nwcs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         mode_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  nwcs_status_t status_i,
  output nwcs_cmd_t    cmd_o
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CHK   = 4'd2;
  localparam logic [3:0] ST_CHKW  = 4'd3;
  localparam logic [3:0] ST_SEGL  = 4'd4;
  localparam logic [3:0] ST_SCAN  = 4'd5;
  localparam logic [3:0] ST_SEGN  = 4'd6;
  localparam logic [3:0] ST_RINGE = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (!status_i.clr_busy) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == MODE_WRITE) begin
            cmd_o.wr_cell = 1'b1;
          end else begin
            cmd_o.q_load = 1'b1;
            state_d      = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        cmd_o.rd_center = 1'b1;
        state_d         = ST_CHKW;
      end
      ST_CHKW: begin
        cmd_o.take_center = 1'b1;
        if (!status_i.center_blocked || status_i.range_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.ring_first = 1'b1;
          state_d          = ST_SEGL;
        end
      end
      ST_SEGL: begin
        cmd_o.seg_load = 1'b1;
        state_d        = status_i.seg_en ? ST_SCAN : ST_SEGN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) state_d = ST_SEGN;
      end
      ST_SEGN: begin
        // last read of the segment is scored in this cycle
        if (status_i.seg_last) begin
          state_d = ST_RINGE;
        end else begin
          cmd_o.seg_next = 1'b1;
          state_d        = ST_SEGL;
        end
      end
      ST_RINGE: begin
        if (status_i.have || status_i.ring_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.ring_next = 1'b1;
          state_d         = ST_SEGL;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before its beat was taken");

  a_clear_holds_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.clr_busy |-> (state_q == ST_CLEAR))
    else $error("controller left clearing state while bitmap still clearing");

  a_scan_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && !status_i.scan_last |=> (state_q == ST_SCAN))
    else $error("segment scan ended before its last cell");

endmodule

[rtl/nearest_walkable_cell_search.sv]
`timescale 1ns / 1ps
// Top level of the nearest walkable cell search block.
// Depends on nwcs_pkg, nwcs_ctrl, nwcs_datapath and nwcs_bitmap.
//
// Usage:
//   Config channel (cfg_valid_i, index, data) is always ready; index 0 sets
//   grid width, 1 grid height, 2 search range. Write it only while idle.
//   Input channel takes one beat per item: mode 1 writes one cell's blocked
//   bit, mode 0 queries the nearest walkable cell. Output channel carries one
//   beat per query and none per write.
// Sequence:
//   A write reaches the bitmap in the cycle it is accepted. A query on a
//   walkable cell, or with range zero, runs no search. A search walks rings
//   out from radius one: four segment setups and ends, one read per segment
//   cell via the single bitmap read port (corners may repeat), one ring decision.
// Reset:
//   Registers return to 64 x 64 grid and search range zero; the bitmap is then
//   cleared one entry per cycle over all min(MAX_WIDTH,64) * min(MAX_HEIGHT,64)
//   entries (4096 by default), while input ready stays low.
// Stall:
//   A held result waits in the output register; writes are still accepted,
//   and a finished query waits until the register is taken.
module nearest_walkable_cell_search import nwcs_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  mode_i,
  input  coord_t                cell_x_i,
  input  coord_t                cell_y_i,
  input  logic                  blocked_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic                  relocated_o,
  output coord_t                result_x_o,
  output coord_t                result_y_o
);

  nwcs_cmd_t    cmd;
  nwcs_status_t status;

  assign cfg_ready_o = 1'b1;

  nwcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nwcs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .blocked_i   (blocked_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .found_o     (found_o),
    .relocated_o (relocated_o),
    .result_x_o  (result_x_o),
    .result_y_o  (result_y_o)
  );

endmodule
